// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the DMA controller.
// No dependencies; the checks vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/fcdma_pkg.sv
// Types, codes and register offsets of the four-channel DMA controller.
// No dependencies; used by four_channel_dma_controller.
package fcdma_pkg;

   localparam int NUM_CHAN = 4;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_LINE  = 2'd2;
   localparam logic [1:0] OP_XFER  = 2'd3;

   localparam logic [1:0] DIR_VERIFY = 2'd0;
   localparam logic [1:0] DIR_IN     = 2'd1;
   localparam logic [1:0] DIR_OUT    = 2'd2;

   localparam logic [3:0] REG_INIT     = 4'd0;
   localparam logic [3:0] REG_SELECT   = 4'd1;
   localparam logic [3:0] REG_COUNT_LO = 4'd2;
   localparam logic [3:0] REG_COUNT_HI = 4'd3;
   localparam logic [3:0] REG_ADDR_LO  = 4'd4;
   localparam logic [3:0] REG_ADDR_MID = 4'd5;
   localparam logic [3:0] REG_ADDR_HI  = 4'd6;
   localparam logic [3:0] REG_CMD_LO   = 4'd8;
   localparam logic [3:0] REG_CMD_HI   = 4'd9;
   localparam logic [3:0] REG_MODE     = 4'd10;
   localparam logic [3:0] REG_STATUS   = 4'd11;
   localparam logic [3:0] REG_TEMP_LO  = 4'd12;
   localparam logic [3:0] REG_TEMP_HI  = 4'd13;
   localparam logic [3:0] REG_SWREQ    = 4'd14;
   localparam logic [3:0] REG_MASK     = 4'd15;

   localparam logic [7:0] MODE_RESET = 8'h04;
   localparam logic [7:0] MASK_RESET = 8'h0f;
   localparam logic [7:0] RDATA_NONE = 8'hff;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } st_type;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] reg_addr;
      logic [7:0] wdata;
      logic [1:0] req_channel;
      logic       req_level;
      logic [7:0] bus_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        xfer_valid;
      logic [1:0]  xfer_channel;
      logic [23:0] xfer_address;
      logic [1:0]  xfer_dir;
      logic        tc_pulse;
   } rsp_type;

   typedef struct packed {
      logic [23:0] cur_addr;
      logic [23:0] base_addr;
      logic [15:0] cur_cnt;
      logic [15:0] base_cnt;
      logic [7:0]  mode;
   } chan_type;

endpackage

// File: rtl/four_channel_dma_controller.sv
// Top level of the four-channel DMA controller: register window and transfer engine.
// Depends on fcdma_pkg and assert_macros.svh.
//
// A request is taken at a rising edge with start high and busy low. It is a
// register write, a register read, a request line change or one bus transfer
// cycle. Every request yields exactly one result: rsp_strobe is high for one
// cycle with rsp_data holding it, and the receiver cannot stall it.
// The per-channel addresses, counts and modes sit in a four-entry memory with
// a registered read. The entry is read at the accepting edge, modified and
// written back in the following cycle, while busy is high. The result appears
// in the cycle after that. Busy stays high until the read-modify-write of the
// channel memory is done, so no new request is taken while one is executing.
// Reset clears the control registers (the mask it sets to 0x0f) and marks every
// memory entry as holding its reset value (zero addresses and counts, mode
// 0x04); a software reset marks only the modes that way. No clearing pass is needed.
`include "assert_macros.svh"

module four_channel_dma_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fcdma_pkg::req_type  req_data,
   output logic                rsp_strobe,
   output fcdma_pkg::rsp_type  rsp_data
);

   fcdma_pkg::st_type   state_ff, state_in;
   fcdma_pkg::chan_type mem [fcdma_pkg::NUM_CHAN];
   fcdma_pkg::chan_type ent_ff, ent, ent_in;
   fcdma_pkg::req_type  req_ff;
   fcdma_pkg::rsp_type  rsp_ff, rsp_in;

   logic [1:0]  ch_ff, rd_idx, pick;
   logic        hit_ff, hit_in;
   logic        rsp_strobe_ff, exec_en, accept, mem_we;
   logic [3:0]  dvld_ff, dvld_in, mvld_ff, mvld_in;
   logic        wide_ff, wide_in, bsel_ff, bsel_in;
   logic [1:0]  sel_ff, sel_in;
   logic [15:0] cmd_ff, cmd_in, temp_ff, temp_in;
   logic [3:0]  hw_ff, hw_in, tc_ff, tc_in, elig, bitv;
   logic [7:0]  sw_ff, sw_in, mask_ff, mask_in;
   logic [1:0]  dir;

   assign accept = start && !busy;
   assign elig   = (hw_ff | sw_ff[3:0]) & ~mask_ff[3:0];
   assign hit_in = !cmd_ff[2] && (elig != 4'd0);

   always_comb begin
      if (elig[0]) begin
         pick = 2'd0;
      end else if (elig[1]) begin
         pick = 2'd1;
      end else if (elig[2]) begin
         pick = 2'd2;
      end else begin
         pick = 2'd3;
      end
      rd_idx = (req_data.op == fcdma_pkg::OP_XFER) ? pick : sel_ff;
   end

   always_comb begin
      case (state_ff)
         fcdma_pkg::ST_IDLE: state_in = accept ? fcdma_pkg::ST_EXEC : fcdma_pkg::ST_IDLE;
         fcdma_pkg::ST_EXEC: state_in = fcdma_pkg::ST_IDLE;
         default:            state_in = fcdma_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         fcdma_pkg::ST_EXEC: begin
            busy    = 1'b1;
            exec_en = 1'b1;
         end
         default: begin
            busy    = 1'b0;
            exec_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      ent.cur_addr  = dvld_ff[ch_ff] ? ent_ff.cur_addr  : 24'd0;
      ent.base_addr = dvld_ff[ch_ff] ? ent_ff.base_addr : 24'd0;
      ent.cur_cnt   = dvld_ff[ch_ff] ? ent_ff.cur_cnt   : 16'd0;
      ent.base_cnt  = dvld_ff[ch_ff] ? ent_ff.base_cnt  : 16'd0;
      ent.mode      = mvld_ff[ch_ff] ? ent_ff.mode      : fcdma_pkg::MODE_RESET;
   end

   always_comb begin
      ent_in  = ent;
      mem_we  = 1'b0;
      rsp_in  = '0;
      dvld_in = dvld_ff;
      mvld_in = mvld_ff;
      wide_in = wide_ff;
      bsel_in = bsel_ff;
      sel_in  = sel_ff;
      cmd_in  = cmd_ff;
      temp_in = temp_ff;
      hw_in   = hw_ff;
      tc_in   = tc_ff;
      sw_in   = sw_ff;
      mask_in = mask_ff;
      bitv    = 4'b0001 << ch_ff;
      case (ent.mode[3:2])
         2'b01:   dir = fcdma_pkg::DIR_IN;
         2'b10:   dir = fcdma_pkg::DIR_OUT;
         default: dir = fcdma_pkg::DIR_VERIFY;
      endcase
      if (exec_en) begin
         case (req_ff.op)
            fcdma_pkg::OP_WRITE: begin
               case (req_ff.reg_addr)
                  fcdma_pkg::REG_INIT: begin
                     if (req_ff.wdata[0]) begin
                        mvld_in = 4'd0;
                        sel_in  = 2'd0;
                        bsel_in = 1'b0;
                        cmd_in  = 16'd0;
                        temp_in = 16'd0;
                        sw_in   = 8'd0;
                        tc_in   = 4'd0;
                        mask_in = fcdma_pkg::MASK_RESET;
                     end
                     wide_in = req_ff.wdata[1];
                  end
                  fcdma_pkg::REG_SELECT: begin
                     sel_in  = req_ff.wdata[1:0];
                     bsel_in = req_ff.wdata[2];
                  end
                  fcdma_pkg::REG_COUNT_LO: begin
                     ent_in.base_cnt[7:0] = req_ff.wdata;
                     ent_in.cur_cnt[7:0]  = req_ff.wdata;
                     mem_we = 1'b1;
                  end
                  fcdma_pkg::REG_COUNT_HI: begin
                     ent_in.base_cnt[15:8] = req_ff.wdata;
                     ent_in.cur_cnt[15:8]  = req_ff.wdata;
                     mem_we = 1'b1;
                  end
                  fcdma_pkg::REG_ADDR_LO: begin
                     ent_in.base_addr[7:0] = req_ff.wdata;
                     ent_in.cur_addr[7:0]  = req_ff.wdata;
                     mem_we = 1'b1;
                  end
                  fcdma_pkg::REG_ADDR_MID: begin
                     ent_in.base_addr[15:8] = req_ff.wdata;
                     ent_in.cur_addr[15:8]  = req_ff.wdata;
                     mem_we = 1'b1;
                  end
                  fcdma_pkg::REG_ADDR_HI: begin
                     ent_in.base_addr[23:16] = req_ff.wdata;
                     ent_in.cur_addr[23:16]  = req_ff.wdata;
                     mem_we = 1'b1;
                  end
                  fcdma_pkg::REG_CMD_LO: cmd_in[7:0]  = req_ff.wdata;
                  fcdma_pkg::REG_CMD_HI: cmd_in[15:8] = req_ff.wdata;
                  fcdma_pkg::REG_MODE: begin
                     ent_in.mode = req_ff.wdata;
                     mem_we = 1'b1;
                  end
                  fcdma_pkg::REG_SWREQ: sw_in   = req_ff.wdata;
                  fcdma_pkg::REG_MASK:  mask_in = req_ff.wdata;
                  default: ;
               endcase
            end
            fcdma_pkg::OP_READ: begin
               case (req_ff.reg_addr)
                  fcdma_pkg::REG_INIT:     rsp_in.rdata = {6'd0, wide_ff, 1'b0};
                  fcdma_pkg::REG_SELECT:
                     rsp_in.rdata = {5'd0, bsel_ff, 2'd0} | (8'd1 << sel_ff);
                  fcdma_pkg::REG_COUNT_LO:
                     rsp_in.rdata = bsel_ff ? ent.base_cnt[7:0] : ent.cur_cnt[7:0];
                  fcdma_pkg::REG_COUNT_HI:
                     rsp_in.rdata = bsel_ff ? ent.base_cnt[15:8] : ent.cur_cnt[15:8];
                  fcdma_pkg::REG_ADDR_LO:
                     rsp_in.rdata = bsel_ff ? ent.base_addr[7:0] : ent.cur_addr[7:0];
                  fcdma_pkg::REG_ADDR_MID:
                     rsp_in.rdata = bsel_ff ? ent.base_addr[15:8] : ent.cur_addr[15:8];
                  fcdma_pkg::REG_ADDR_HI:
                     rsp_in.rdata = bsel_ff ? ent.base_addr[23:16] : ent.cur_addr[23:16];
                  fcdma_pkg::REG_CMD_LO:   rsp_in.rdata = cmd_ff[7:0];
                  fcdma_pkg::REG_CMD_HI:   rsp_in.rdata = cmd_ff[15:8];
                  fcdma_pkg::REG_MODE:     rsp_in.rdata = ent.mode;
                  fcdma_pkg::REG_STATUS: begin
                     rsp_in.rdata = {hw_ff, tc_ff};
                     tc_in = 4'd0;
                  end
                  fcdma_pkg::REG_TEMP_LO:  rsp_in.rdata = temp_ff[7:0];
                  fcdma_pkg::REG_TEMP_HI:  rsp_in.rdata = temp_ff[15:8];
                  fcdma_pkg::REG_SWREQ:    rsp_in.rdata = sw_ff;
                  fcdma_pkg::REG_MASK:     rsp_in.rdata = mask_ff;
                  default:                 rsp_in.rdata = fcdma_pkg::RDATA_NONE;
               endcase
            end
            fcdma_pkg::OP_LINE: begin
               hw_in[req_ff.req_channel] = req_ff.req_level;
            end
            default: begin
               if (hit_ff) begin
                  rsp_in.xfer_valid   = 1'b1;
                  rsp_in.xfer_channel = ch_ff;
                  rsp_in.xfer_address = ent.cur_addr;
                  rsp_in.xfer_dir     = dir;
                  if (dir != fcdma_pkg::DIR_VERIFY) begin
                     temp_in = {req_ff.bus_data, temp_ff[15:8]};
                  end
                  ent_in.cur_addr = ent.mode[5] ? ent.cur_addr - 24'd1
                                                : ent.cur_addr + 24'd1;
                  if (ent.cur_cnt == 16'd0) begin
                     ent_in.cur_cnt = 16'hffff;
                     if (ent.mode[4]) begin
                        ent_in.cur_addr = ent.base_addr;
                        ent_in.cur_cnt  = ent.base_cnt;
                     end else begin
                        mask_in = mask_ff | {4'd0, bitv};
                     end
                     hw_in = hw_ff & ~bitv;
                     sw_in = sw_ff & ~{4'd0, bitv};
                     tc_in = tc_ff | bitv;
                     rsp_in.tc_pulse = 1'b1;
                  end else begin
                     ent_in.cur_cnt = ent.cur_cnt - 16'd1;
                  end
                  mem_we = 1'b1;
               end
            end
         endcase
         if (mem_we) begin
            dvld_in[ch_ff] = 1'b1;
            mvld_in[ch_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fcdma_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         hit_ff        <= 1'b0;
         dvld_ff       <= 4'd0;
         mvld_ff       <= 4'd0;
         wide_ff       <= 1'b0;
         bsel_ff       <= 1'b0;
         sel_ff        <= 2'd0;
         cmd_ff        <= 16'd0;
         temp_ff       <= 16'd0;
         hw_ff         <= 4'd0;
         tc_ff         <= 4'd0;
         sw_ff         <= 8'd0;
         mask_ff       <= fcdma_pkg::MASK_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= exec_en;
         if (accept) begin
            hit_ff <= hit_in;
         end
         dvld_ff <= dvld_in;
         mvld_ff <= mvld_in;
         wide_ff <= wide_in;
         bsel_ff <= bsel_in;
         sel_ff  <= sel_in;
         cmd_ff  <= cmd_in;
         temp_ff <= temp_in;
         hw_ff   <= hw_in;
         tc_ff   <= tc_in;
         sw_ff   <= sw_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff <= mem[rd_idx];
         req_ff <= req_data;
         ch_ff  <= rd_idx;
      end
      if (mem_we) begin
         mem[ch_ff] <= ent_in;
      end
      if (exec_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == fcdma_pkg::ST_EXEC, "accepted request did not enter execution")
   `ASSERT_IMPL(a_strobe_after_exec, clock, reset, rsp_strobe, $past(state_ff == fcdma_pkg::ST_EXEC), "result strobe without execution")
   `ASSERT_IMPL(a_tc_needs_xfer, clock, reset, rsp_strobe && rsp_data.tc_pulse, rsp_data.xfer_valid, "terminal count without transfer")
   `ASSERT_IMPL(a_no_xfer_disabled, clock, reset, exec_en && req_ff.op == fcdma_pkg::OP_XFER && cmd_ff[2], !hit_ff, "transfer while DMA disabled")

endmodule
